[rtl/core/hcc_pkg.sv]
// ----------------------------------------------------------------------------
// hcc_pkg
// shared constants and helpers for the hash code combiner
// ----------------------------------------------------------------------------
package hcc_pkg;

	localparam logic [31:0] PRIME1 = 32'd2654435761;
	localparam logic [31:0] PRIME2 = 32'd2246822519;
	localparam logic [31:0] PRIME3 = 32'd3266489917;
	localparam logic [31:0] PRIME4 = 32'd668265263;
	localparam logic [31:0] PRIME5 = 32'd374761393;

	localparam logic [31:0] LEN_TWO   = 32'd8;
	localparam logic [31:0] LEN_THREE = 32'd12;
	localparam logic [31:0] LEN_FOUR  = 32'd16;

	localparam logic [4:0] ROT_ACC   = 5'd13;
	localparam logic [4:0] ROT_QUEUE = 5'd17;

	localparam int unsigned SHIFT_AV1 = 15;
	localparam int unsigned SHIFT_AV2 = 13;
	localparam int unsigned SHIFT_AV3 = 16;

	typedef enum logic [1:0] {
		REQ_TWO   = 2'd0,
		REQ_THREE = 2'd1,
		REQ_FOUR  = 2'd2,
		REQ_ALIAS = 2'd3
	} req_type_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
		logic [63:0] dbl;
		dbl = {v, v} << r;
		return dbl[63:32];
	endfunction

endpackage

[rtl/core/hcc_round_front.sv]
// ----------------------------------------------------------------------------
// hcc_round_front
// four-stage round pipeline: lane products, accumulator or queue rounds,
// lane merge, and the third queue round
// ----------------------------------------------------------------------------
module hcc_round_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] value_a,
	input  logic [31:0] value_b,
	input  logic [31:0] value_c,
	input  logic [31:0] value_d,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_hash
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        adv1, adv2, adv3, adv4;

	logic        four_s1, three_s1;
	logic [31:0] prod_s1 [4];

	logic        four_s2, three_s2;
	logic [31:0] lane_s2 [4];
	logic [31:0] pb_s2, pc_s2;

	logic        three_s3;
	logic [31:0] h_s3, pc_s3;

	logic [31:0] h_s4;

	logic        four_in, three_in;
	logic [31:0] lane_mul1;
	logic [31:0] acc_init [4];
	logic [31:0] queue_init;
	logic [31:0] lane_next [4];
	logic [31:0] merge_sum, queue_b, queue_c;

	assign adv4     = !valid_s4 || !out_stall;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	assign four_in  = req_type[1];
	assign three_in = (req_type == hcc_pkg::REQ_THREE);
	assign lane_mul1 = four_in ? hcc_pkg::PRIME2 : hcc_pkg::PRIME3;

	// initial accumulators
	always_comb begin
		acc_init[0] = seed + hcc_pkg::PRIME1 + hcc_pkg::PRIME2;
		acc_init[1] = seed + hcc_pkg::PRIME2;
		acc_init[2] = seed;
		acc_init[3] = seed - hcc_pkg::PRIME1;
		queue_init  = seed + hcc_pkg::PRIME5
			+ (three_s1 ? hcc_pkg::LEN_THREE : hcc_pkg::LEN_TWO);
	end

	// round of each lane; lane 0 also serves the first queue round
	always_comb begin
		if (four_s1) begin
			lane_next[0] = hcc_pkg::rotl32(acc_init[0] + prod_s1[0], hcc_pkg::ROT_ACC)
				* hcc_pkg::PRIME1;
		end else begin
			lane_next[0] = hcc_pkg::rotl32(queue_init + prod_s1[0], hcc_pkg::ROT_QUEUE)
				* hcc_pkg::PRIME4;
		end
		for (int i = 1; i < 4; i++) begin
			lane_next[i] = hcc_pkg::rotl32(acc_init[i] + prod_s1[i], hcc_pkg::ROT_ACC)
				* hcc_pkg::PRIME1;
		end
	end

	always_comb begin
		merge_sum = hcc_pkg::rotl32(lane_s2[0], 5'd1) + hcc_pkg::rotl32(lane_s2[1], 5'd7)
			+ hcc_pkg::rotl32(lane_s2[2], 5'd12) + hcc_pkg::rotl32(lane_s2[3], 5'd18)
			+ hcc_pkg::LEN_FOUR;
		queue_b = hcc_pkg::rotl32(lane_s2[0] + pb_s2, hcc_pkg::ROT_QUEUE) * hcc_pkg::PRIME4;
		queue_c = hcc_pkg::rotl32(h_s3 + pc_s3, hcc_pkg::ROT_QUEUE) * hcc_pkg::PRIME4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			four_s1    <= four_in;
			three_s1   <= three_in;
			prod_s1[0] <= value_a * lane_mul1;
			prod_s1[1] <= value_b * lane_mul1;
			prod_s1[2] <= value_c * lane_mul1;
			prod_s1[3] <= value_d * hcc_pkg::PRIME2;
		end
		if (adv2 && valid_s1) begin
			four_s2  <= four_s1;
			three_s2 <= three_s1;
			for (int i = 0; i < 4; i++) begin
				lane_s2[i] <= lane_next[i];
			end
			pb_s2 <= prod_s1[1];
			pc_s2 <= prod_s1[2];
		end
		if (adv3 && valid_s2) begin
			three_s3 <= three_s2;
			h_s3     <= four_s2 ? merge_sum : queue_b;
			pc_s3    <= pc_s2;
		end
		if (adv4 && valid_s3) begin
			h_s4 <= three_s3 ? queue_c : h_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_hash  = h_s4;

endmodule

[rtl/core/hcc_avalanche.sv]
// ----------------------------------------------------------------------------
// hcc_avalanche
// two-stage avalanche finalizer with the last xor-shift on the output
// ----------------------------------------------------------------------------
module hcc_avalanche (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] in_hash,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_hash
);

	logic        valid_s5, valid_s6;
	logic        adv5, adv6;
	logic [31:0] h_s5, h_s6;
	logic [31:0] mix5, mix6;

	assign adv6     = !valid_s6 || !out_stall;
	assign adv5     = !valid_s5 || adv6;
	assign in_stall = !adv5;

	assign mix5 = in_hash ^ (in_hash >> hcc_pkg::SHIFT_AV1);
	assign mix6 = h_s5 ^ (h_s5 >> hcc_pkg::SHIFT_AV2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv5) valid_s5 <= in_valid;
			if (adv6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv5 && in_valid) h_s5 <= mix5 * hcc_pkg::PRIME2;
		if (adv6 && valid_s5) h_s6 <= mix6 * hcc_pkg::PRIME3;
	end

	assign out_valid = valid_s6;
	assign out_hash  = h_s6 ^ (h_s6 >> hcc_pkg::SHIFT_AV3);

endmodule

[rtl/core/hash_code_combine.sv]
// ----------------------------------------------------------------------------
// hash_code_combine
// combines two, three or four 32-bit hash codes into one 32-bit hash
// ----------------------------------------------------------------------------
// pipeline: six register stages, four in hcc_round_front and two in hcc_avalanche
// throughput: one item per cycle while out_stall is low, set by the six-stage multiplier pipeline
// every stage holds its item under stall; empty stages still fill
// reset: clears all valid bits and the seed register to zero
// ----------------------------------------------------------------------------
module hash_code_combine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [31:0]        value_a,
	input  logic [31:0]        value_b,
	input  logic [31:0]        value_c,
	input  logic [31:0]        value_d,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] combined_hash
);

	logic [31:0] seed_q;
	logic        mid_valid, mid_stall;
	logic [31:0] mid_hash;
	logic [31:0] final_hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr_en) begin
			seed_q <= cfg_wr_data;
		end
	end

	hcc_round_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.value_a   (value_a),
		.value_b   (value_b),
		.value_c   (value_c),
		.value_d   (value_d),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.out_hash  (mid_hash)
	);

	hcc_avalanche u_aval (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.in_hash   (mid_hash),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_hash  (final_hash)
	);

	assign combined_hash = signed'(final_hash);

endmodule

[sim/hash_code_combine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_code_combine_tb
// self-checking regression for the hash code combiner
//
// Items of all four request types are sent under random valid and stall gaps,
// with a stretch of full-rate traffic. Every accepted item is hashed by a
// predictor built into the bench, and each result is checked in order.
// The seed register is swept across its extremes between traffic phases,
// and the pipeline is drained before each write.
// ----------------------------------------------------------------------------
module hash_code_combine_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 12;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [31:0]        cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = hcc_pkg::REQ_TWO;
	logic [31:0]        value_a = '0;
	logic [31:0]        value_b = '0;
	logic [31:0]        value_c = '0;
	logic [31:0]        value_d = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] combined_hash;

	logic [31:0] seed_model = '0;
	logic [31:0] hash_expect_q[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	hash_code_combine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.value_a       (value_a),
		.value_b       (value_b),
		.value_c       (value_c),
		.value_d       (value_d),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.combined_hash (combined_hash)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// hash predictor
	function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned r);
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] lane_mix(input logic [31:0] acc, input logic [31:0] x);
		return rol32(acc + x * hcc_pkg::PRIME2, 13) * hcc_pkg::PRIME1;
	endfunction

	function automatic logic [31:0] chain_mix(input logic [31:0] acc, input logic [31:0] x);
		return rol32(acc + x * hcc_pkg::PRIME3, 17) * hcc_pkg::PRIME4;
	endfunction

	function automatic logic [31:0] final_mix(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 15);
		t = t * hcc_pkg::PRIME2;
		t = t ^ (t >> 13);
		t = t * hcc_pkg::PRIME3;
		return t ^ (t >> 16);
	endfunction

	function automatic logic [31:0] expected_hash(input logic [31:0] seed, input logic [1:0] sel,
			input logic [31:0] a, input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		logic [31:0] h;
		if (sel[1]) begin
			// four lanes, selector three decodes the same way
			h = rol32(lane_mix(seed + hcc_pkg::PRIME1 + hcc_pkg::PRIME2, a), 1)
				+ rol32(lane_mix(seed + hcc_pkg::PRIME2, b), 7)
				+ rol32(lane_mix(seed, c), 12)
				+ rol32(lane_mix(seed - hcc_pkg::PRIME1, d), 18);
			h = h + hcc_pkg::LEN_FOUR;
		end else if (sel == hcc_pkg::REQ_THREE) begin
			h = seed + hcc_pkg::PRIME5 + hcc_pkg::LEN_THREE;
			h = chain_mix(chain_mix(chain_mix(h, a), b), c);
		end else begin
			h = seed + hcc_pkg::PRIME5 + hcc_pkg::LEN_TWO;
			h = chain_mix(chain_mix(h, a), b);
		end
		return final_mix(h);
	endfunction

	function automatic logic [31:0] pick_value();
		int unsigned bitpos;
		bitpos = $urandom_range(31);
		case ($urandom_range(9))
		0: begin
			return 32'h0000_0000;
		end
		1: begin
			return 32'hFFFF_FFFF;
		end
		2: begin
			return 32'h1 << bitpos;
		end
		3: begin
			return ~(32'h1 << bitpos);
		end
		default: begin
			return $urandom();
		end
		endcase
	endfunction

	// receiver stall
	always @(posedge clk) begin
		out_stall <= rx_idle_on && ($urandom_range(99) < 35);
	end

	// predict on acceptance, check on delivery
	always @(posedge clk) begin : hash_check
		logic [31:0] want;
		if (arst_n && in_valid && !in_stall) begin
			hash_expect_q.push_back(expected_hash(seed_model, req_type,
				value_a, value_b, value_c, value_d));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (hash_expect_q.size() == 0) begin
				fail_count++;
				$error("combined_hash: no item pending, expected none, actual %h",
					combined_hash);
			end else begin
				want = hash_expect_q.pop_front();
				if (combined_hash !== want) begin
					fail_count++;
					$error("combined_hash mismatch: expected %h, actual %h", want, combined_hash);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("hash_code_combine regression: fail");
			$finish;
		end
	end

	task automatic send_item(input hcc_pkg::req_type_t sel, input logic [31:0] a,
			input logic [31:0] b, input logic [31:0] c, input logic [31:0] d);
		if (tx_idle_on) begin
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= sel;
		value_a  <= a;
		value_b  <= b;
		value_c  <= c;
		value_d  <= d;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_item();
		send_item(hcc_pkg::req_type_t'($urandom_range(3)), pick_value(), pick_value(),
			pick_value(), pick_value());
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (hash_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		seed_model = v;
	endtask

	// every request type at the value extremes, then unused values changed
	task automatic test_value_extremes();
		hcc_pkg::req_type_t sel_list[4];
		logic [31:0] a;
		logic [31:0] b;
		sel_list = '{hcc_pkg::REQ_TWO, hcc_pkg::REQ_THREE, hcc_pkg::REQ_FOUR,
			hcc_pkg::REQ_ALIAS};
		foreach (sel_list[i]) begin
			send_item(sel_list[i], 32'h0, 32'h0, 32'h0, 32'h0);
			send_item(sel_list[i], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			send_item(sel_list[i], 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
		end
		a = $urandom();
		b = $urandom();
		// values beyond the count must not matter
		send_item(hcc_pkg::REQ_TWO, a, b, 32'h0, 32'h0);
		send_item(hcc_pkg::REQ_TWO, a, b, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(hcc_pkg::REQ_TWO, a, b, $urandom(), $urandom());
		send_item(hcc_pkg::REQ_THREE, a, b, 32'h1234_5678, 32'h0);
		send_item(hcc_pkg::REQ_THREE, a, b, 32'h1234_5678, 32'hFFFF_FFFF);
	endtask

	task automatic test_seed_extremes();
		logic [31:0] seeds[4];
		seeds = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, $urandom()};
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			repeat (2) begin
				send_item(hcc_pkg::REQ_TWO, pick_value(), pick_value(), pick_value(),
					pick_value());
				send_item(hcc_pkg::REQ_THREE, pick_value(), pick_value(), pick_value(),
					pick_value());
				send_item(hcc_pkg::REQ_FOUR, pick_value(), pick_value(), pick_value(),
					pick_value());
				send_item(hcc_pkg::REQ_ALIAS, pick_value(), pick_value(), pick_value(),
					pick_value());
			end
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (300) send_random_item();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				write_seed(32'h0000_0000);
			end else if (phase == 1) begin
				write_seed(32'hFFFF_FFFF);
			end else begin
				write_seed($urandom());
			end
			repeat (160) send_random_item();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_value_extremes();
		test_seed_extremes();
		test_back_to_back();
		test_random_traffic();
		drain_pipeline();
		if (fail_count == 0) begin
			$display("hash_code_combine regression: pass");
		end else begin
			$display("hash_code_combine regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/hcc_pkg.sv
rtl/core/hcc_round_front.sv
rtl/core/hcc_avalanche.sv
rtl/core/hash_code_combine.sv
sim/hash_code_combine_tb.sv
